// ===== rtl/mtee_pkg.sv =====
package mtee_pkg;

    typedef enum logic [1:0] {
        MODE_DELAY   = 2'd0,
        MODE_CHANNEL = 2'd1,
        MODE_META    = 2'd2,
        MODE_PAYLOAD = 2'd3
    } t_mode;

    localparam int DELAY_W     = 28;
    localparam int GROUP_W     = 7;
    localparam int BYTE_W      = 8;
    localparam int MAX_BYTES   = 7;
    localparam int CNT_W       = 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [BYTE_W-1:0] CONT_BIT  = 8'h80;
    localparam logic [BYTE_W-1:0] META_BYTE = 8'hFF;

    typedef struct packed {
        logic [MAX_BYTES-1:0][BYTE_W-1:0] bytes;
        logic [CNT_W-1:0]                 count;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

// ===== rtl/mtee_front.sv =====
module mtee_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [1:0]                  i_mode,
    input  logic [27:0]                 i_delay_amount,
    input  logic [7:0]                  i_status_byte,
    input  logic [1:0]                  i_data_count,
    input  logic [6:0]                  i_first_data,
    input  logic [6:0]                  i_second_data,
    input  logic [6:0]                  i_meta_type,
    input  logic [7:0]                  i_meta_length,
    input  logic [7:0]                  i_payload_byte,
    output mtee_pkg::t_job              o_job
);

    logic [mtee_pkg::DELAY_W-1:0] r_pending_delay;
    logic [mtee_pkg::DELAY_W-1:0] n_pending_delay;
    logic [mtee_pkg::BYTE_W-1:0]  r_last_status;
    logic [mtee_pkg::BYTE_W-1:0]  n_last_status;

    mtee_pkg::t_mode                        w_mode;
    logic [mtee_pkg::DELAY_W:0]             w_sum;
    logic [mtee_pkg::CNT_W-1:0]             w_dlen;
    logic [mtee_pkg::CNT_W-1:0]             w_dlen_used;
    logic [mtee_pkg::CNT_W-1:0]             w_elen;
    logic [3:0][mtee_pkg::BYTE_W-1:0]       w_dbytes;
    logic [2:0][mtee_pkg::BYTE_W-1:0]       w_ebytes;
    logic [1:0]                             w_dcnt;
    logic [mtee_pkg::GROUP_W-1:0]           w_g3;
    logic [mtee_pkg::GROUP_W-1:0]           w_g2;
    logic [mtee_pkg::GROUP_W-1:0]           w_g1;
    logic [mtee_pkg::GROUP_W-1:0]           w_g0;

    assign w_mode = mtee_pkg::t_mode'(i_mode);
    assign w_sum  = {1'b0, r_pending_delay} + {1'b0, i_delay_amount};
    assign w_g3   = r_pending_delay[27:21];
    assign w_g2   = r_pending_delay[20:14];
    assign w_g1   = r_pending_delay[13:7];
    assign w_g0   = r_pending_delay[6:0];
    assign w_dcnt = (i_data_count == 2'd3) ? 2'd2 : i_data_count;

    // The delay is sent most significant group first, with the top bit set on
    // every byte but the last one.
    always_comb begin
        w_dbytes = '0;
        if (w_g3 != '0) begin
            w_dlen      = 3'd4;
            w_dbytes[0] = mtee_pkg::CONT_BIT | {1'b0, w_g3};
            w_dbytes[1] = mtee_pkg::CONT_BIT | {1'b0, w_g2};
            w_dbytes[2] = mtee_pkg::CONT_BIT | {1'b0, w_g1};
            w_dbytes[3] = {1'b0, w_g0};
        end else if (w_g2 != '0) begin
            w_dlen      = 3'd3;
            w_dbytes[0] = mtee_pkg::CONT_BIT | {1'b0, w_g2};
            w_dbytes[1] = mtee_pkg::CONT_BIT | {1'b0, w_g1};
            w_dbytes[2] = {1'b0, w_g0};
        end else if (w_g1 != '0) begin
            w_dlen      = 3'd2;
            w_dbytes[0] = mtee_pkg::CONT_BIT | {1'b0, w_g1};
            w_dbytes[1] = {1'b0, w_g0};
        end else begin
            w_dlen      = 3'd1;
            w_dbytes[0] = {1'b0, w_g0};
        end
    end

    always_comb begin
        w_ebytes    = '0;
        w_elen      = '0;
        w_dlen_used = '0;
        case (w_mode)
            mtee_pkg::MODE_CHANNEL: begin
                w_dlen_used = w_dlen;
                if (i_status_byte != r_last_status) begin
                    w_ebytes[0] = i_status_byte;
                    w_ebytes[1] = {1'b0, i_first_data};
                    w_ebytes[2] = {1'b0, i_second_data};
                    w_elen      = {1'b0, w_dcnt} + 3'd1;
                end else begin
                    w_ebytes[0] = {1'b0, i_first_data};
                    w_ebytes[1] = {1'b0, i_second_data};
                    w_elen      = {1'b0, w_dcnt};
                end
            end
            mtee_pkg::MODE_META: begin
                w_dlen_used = w_dlen;
                w_ebytes[0] = mtee_pkg::META_BYTE;
                w_ebytes[1] = {1'b0, i_meta_type};
                w_ebytes[2] = i_meta_length;
                w_elen      = 3'd3;
            end
            mtee_pkg::MODE_PAYLOAD: begin
                w_ebytes[0] = i_payload_byte;
                w_elen      = 3'd1;
            end
            default: begin
                w_elen = '0;
            end
        endcase
    end

    always_comb begin
        logic [mtee_pkg::CNT_W-1:0] kk;
        logic [mtee_pkg::CNT_W-1:0] off;
        o_job.bytes = '0;
        for (int k = 0; k < mtee_pkg::MAX_BYTES; k++) begin
            kk  = mtee_pkg::CNT_W'(k);
            off = kk - w_dlen_used;
            if (kk < w_dlen_used) begin
                o_job.bytes[k] = w_dbytes[kk[1:0]];
            end else if (off < 3'd3) begin
                o_job.bytes[k] = w_ebytes[off[1:0]];
            end
        end
        o_job.count = w_dlen_used + w_elen;
    end

    always_comb begin
        n_pending_delay = r_pending_delay;
        n_last_status   = r_last_status;
        if (i_accept) begin
            case (w_mode)
                mtee_pkg::MODE_DELAY: begin
                    n_pending_delay = w_sum[mtee_pkg::DELAY_W] ? '1
                                    : w_sum[mtee_pkg::DELAY_W-1:0];
                end
                mtee_pkg::MODE_CHANNEL: begin
                    n_pending_delay = '0;
                    n_last_status   = i_status_byte;
                end
                mtee_pkg::MODE_META: begin
                    n_pending_delay = '0;
                end
                default: begin
                    n_pending_delay = r_pending_delay;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_delay <= '0;
            r_last_status   <= '0;
        end else begin
            r_pending_delay <= n_pending_delay;
            r_last_status   <= n_last_status;
        end
    end

endmodule

// ===== rtl/mtee_queue.sv =====
module mtee_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mtee_pkg::t_job  i_job,
    input  logic            i_pop,
    output mtee_pkg::t_job  o_head,
    output mtee_pkg::t_qstat o_qstat
);

    mtee_pkg::t_job                r_mem [mtee_pkg::QUEUE_DEPTH];
    logic [mtee_pkg::QPTR_W-1:0]   r_wptr;
    logic [mtee_pkg::QPTR_W-1:0]   r_rptr;
    logic [mtee_pkg::QCNT_W-1:0]   r_count;
    logic [mtee_pkg::QPTR_W-1:0]   n_wptr;
    logic [mtee_pkg::QPTR_W-1:0]   n_rptr;
    logic [mtee_pkg::QCNT_W-1:0]   n_count;

    assign o_head        = r_mem[r_rptr];
    assign o_qstat.full  = (r_count == mtee_pkg::QCNT_W'(mtee_pkg::QUEUE_DEPTH));
    assign o_qstat.empty = (r_count == '0);

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/mtee_back.sv =====
module mtee_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mtee_pkg::t_job   i_job,
    input  mtee_pkg::t_qstat i_qstat,
    input  logic             i_stall,
    output logic             o_pop,
    output logic             o_valid,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_item
);

    logic                         r_out_valid;
    logic                         n_out_valid;
    logic [mtee_pkg::CNT_W-1:0]   r_idx;
    logic [mtee_pkg::CNT_W-1:0]   n_idx;
    logic [mtee_pkg::BYTE_W-1:0]  r_out_byte;
    logic                         r_last;
    logic                         w_load;
    logic                         w_emit;
    logic                         w_last;

    assign w_load = !r_out_valid || !i_stall;
    assign w_emit = w_load && !i_qstat.empty;
    assign w_last = (r_idx == i_job.count - 3'd1);
    assign o_pop  = w_emit && w_last;

    always_comb begin
        n_out_valid = w_load ? !i_qstat.empty : r_out_valid;
        n_idx       = r_idx;
        if (w_emit) begin
            n_idx = w_last ? '0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_byte <= i_job.bytes[r_idx];
            r_last     <= w_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_last_of_item = r_last;

endmodule

// ===== rtl/midi_track_event_encoder_top.sv =====
// With the queue empty and the output idle, the first byte of a request passes through the queue
// entry and then the registered output byte before it shows at the output.
// Throughput: one output byte per cycle while the output is not stalled; a request that produces
// bytes has one to seven of them, and a delay request produces no byte.
// A four-entry queue between the front and the output serializer absorbs output stalls.
// Synchronous active-low reset clears the pending delay, the running status and the queue.
module midi_track_event_encoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [27:0] i_delay_amount,
    input  logic [7:0]  i_status_byte,
    input  logic [1:0]  i_data_count,
    input  logic [6:0]  i_first_data,
    input  logic [6:0]  i_second_data,
    input  logic [6:0]  i_meta_type,
    input  logic [7:0]  i_meta_length,
    input  logic [7:0]  i_payload_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_of_item
);

    mtee_pkg::t_job   w_new_job;
    mtee_pkg::t_job   w_head;
    mtee_pkg::t_qstat w_qstat;
    logic             w_accept;
    logic             w_push;
    logic             w_pop;

    assign o_stall  = w_qstat.full;
    assign w_accept = i_valid && !w_qstat.full;
    assign w_push   = w_accept && (i_mode != mtee_pkg::MODE_DELAY);

    mtee_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_mode         (i_mode),
        .i_delay_amount (i_delay_amount),
        .i_status_byte  (i_status_byte),
        .i_data_count   (i_data_count),
        .i_first_data   (i_first_data),
        .i_second_data  (i_second_data),
        .i_meta_type    (i_meta_type),
        .i_meta_length  (i_meta_length),
        .i_payload_byte (i_payload_byte),
        .o_job          (w_new_job)
    );

    mtee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_new_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_qstat (w_qstat)
    );

    mtee_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_job          (w_head),
        .i_qstat        (w_qstat),
        .i_stall        (i_stall),
        .o_pop          (w_pop),
        .o_valid        (o_valid),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

endmodule

// ===== rtl/mtee_checker.sv =====
module mtee_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_out_byte,
    input logic       o_last_of_item
);

    // A stalled output byte holds until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_last_of_item))
        else $error("output byte changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // The bytes of one request leave without gaps.
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_of_item |=> o_valid)
        else $error("gap inside a request");

    // While the queue is full, a byte is always presented at the output.
    a_full_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with an idle output");

endmodule

bind midi_track_event_encoder_top mtee_checker u_mtee_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_out_byte     (o_out_byte),
    .o_last_of_item (o_last_of_item)
);

// ===== tb/tb_top.sv =====
typedef struct packed {
    mtee_pkg::t_mode mode;
    logic [27:0]     delay_amount;
    logic [7:0]      status_byte;
    logic [1:0]      data_count;
    logic [6:0]      first_data;
    logic [6:0]      second_data;
    logic [6:0]      meta_type;
    logic [7:0]      meta_length;
    logic [7:0]      payload_byte;
} t_request;

typedef struct {
    logic [7:0] value;
    logic       last;
} t_track_byte;

class track_stream_model;
    logic [27:0] pending_delay;
    logic [7:0]  prev_status;
    logic [7:0]  burst[$];
    t_track_byte expected_track_bytes[$];
    int          mismatches;
    int          bytes_checked;
    int          requests_noted;

    function new();
        pending_delay  = '0;
        prev_status    = '0;
        mismatches     = 0;
        bytes_checked  = 0;
        requests_noted = 0;
    endfunction

    function int pending();
        return expected_track_bytes.size();
    endfunction

    function void add_byte(logic [7:0] b);
        burst = {burst, b};
    endfunction

    // The delta time goes out most significant group first, with the
    // continuation bit on every byte except the last one.
    function void push_delay();
        logic [27:0] t;
        t = pending_delay;
        if (t[27:21] != '0) add_byte(mtee_pkg::CONT_BIT | {1'b0, t[27:21]});
        if (t[27:14] != '0) add_byte(mtee_pkg::CONT_BIT | {1'b0, t[20:14]});
        if (t[27:7] != '0)  add_byte(mtee_pkg::CONT_BIT | {1'b0, t[13:7]});
        add_byte({1'b0, t[6:0]});
        pending_delay = '0;
    endfunction

    function void note_request(t_request req);
        logic [28:0] sum;
        logic [1:0]  cnt;
        t_track_byte item;
        burst.delete();
        case (req.mode)
            mtee_pkg::MODE_DELAY: begin
                sum = {1'b0, pending_delay} + {1'b0, req.delay_amount};
                pending_delay = sum[28] ? '1 : sum[27:0];
            end
            mtee_pkg::MODE_CHANNEL: begin
                cnt = (req.data_count == 2'd3) ? 2'd2 : req.data_count;
                push_delay();
                if (req.status_byte != prev_status) begin
                    prev_status = req.status_byte;
                    add_byte(req.status_byte);
                end
                if (cnt >= 2'd1) add_byte({1'b0, req.first_data});
                if (cnt == 2'd2) add_byte({1'b0, req.second_data});
            end
            mtee_pkg::MODE_META: begin
                push_delay();
                add_byte(mtee_pkg::META_BYTE);
                add_byte({1'b0, req.meta_type});
                add_byte(req.meta_length);
            end
            default: begin
                add_byte(req.payload_byte);
            end
        endcase
        foreach (burst[i]) begin
            item.value = burst[i];
            item.last  = (i == burst.size() - 1);
            expected_track_bytes = {expected_track_bytes, item};
        end
        requests_noted++;
    endfunction

    function void check_byte(logic [7:0] value, logic last);
        t_track_byte exp;
        bytes_checked++;
        if (expected_track_bytes.size() == 0) begin
            $display("%0t: unexpected byte %02h (last %0b), nothing expected",
                     $time, value, last);
            mismatches++;
            return;
        end
        exp = expected_track_bytes.pop_front();
        if (value !== exp.value) begin
            $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                     $time, exp.value, value);
            mismatches++;
        end
        if (last !== exp.last) begin
            $display("%0t: last_of_item mismatch, expected %0b, actual %0b",
                     $time, exp.last, last);
            mismatches++;
        end
    endfunction
endclass

module tb_top;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        o_stall;
    logic [1:0]  i_mode         = '0;
    logic [27:0] i_delay_amount = '0;
    logic [7:0]  i_status_byte  = '0;
    logic [1:0]  i_data_count   = '0;
    logic [6:0]  i_first_data   = '0;
    logic [6:0]  i_second_data  = '0;
    logic [6:0]  i_meta_type    = '0;
    logic [7:0]  i_meta_length  = '0;
    logic [7:0]  i_payload_byte = '0;
    logic        o_valid;
    logic        i_stall        = 1'b0;
    logic [7:0]  o_out_byte;
    logic        o_last_of_item;

    track_stream_model sb = new();
    bit no_idle = 1'b0;
    int directed_count;

    midi_track_event_encoder_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_delay_amount (i_delay_amount),
        .i_status_byte  (i_status_byte),
        .i_data_count   (i_data_count),
        .i_first_data   (i_first_data),
        .i_second_data  (i_second_data),
        .i_meta_type    (i_meta_type),
        .i_meta_length  (i_meta_length),
        .i_payload_byte (i_payload_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_last_of_item (o_last_of_item)
    );

    always #4 i_clk = ~i_clk;

    function automatic t_request random_request(mtee_pkg::t_mode mode);
        t_request req;
        req.mode         = mode;
        req.delay_amount = 28'($urandom);
        req.status_byte  = 8'($urandom);
        req.data_count   = 2'($urandom);
        req.first_data   = 7'($urandom);
        req.second_data  = 7'($urandom);
        req.meta_type    = 7'($urandom);
        req.meta_length  = 8'($urandom);
        req.payload_byte = 8'($urandom);
        return req;
    endfunction

    function automatic logic [27:0] random_delay();
        case ($urandom_range(0, 7))
            0: return 28'h7F;
            1: return 28'h80;
            2: return 28'h3FFF;
            3: return 28'h4000;
            4: return 28'h1FFFFF;
            5: return 28'h200000;
            6: return 28'($urandom);
            default: return 28'($urandom_range(0, 300));
        endcase
    endfunction

    function automatic logic [7:0] random_status();
        if ($urandom_range(0, 2) == 0) return 8'($urandom);
        return 8'h90 | 8'($urandom_range(0, 1));
    endfunction

    task automatic send_request(input t_request req);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_mode         <= req.mode;
        i_delay_amount <= req.delay_amount;
        i_status_byte  <= req.status_byte;
        i_data_count   <= req.data_count;
        i_first_data   <= req.first_data;
        i_second_data  <= req.second_data;
        i_meta_type    <= req.meta_type;
        i_meta_length  <= req.meta_length;
        i_payload_byte <= req.payload_byte;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_request(req);
    endtask

    task automatic send_delay(input logic [27:0] amount);
        t_request req;
        req = random_request(mtee_pkg::MODE_DELAY);
        req.delay_amount = amount;
        send_request(req);
    endtask

    task automatic send_channel(input logic [7:0] status, input logic [1:0] count,
                                input logic [6:0] d1, input logic [6:0] d2);
        t_request req;
        req = random_request(mtee_pkg::MODE_CHANNEL);
        req.status_byte = status;
        req.data_count  = count;
        req.first_data  = d1;
        req.second_data = d2;
        send_request(req);
    endtask

    task automatic send_meta(input logic [6:0] mtype, input logic [7:0] length);
        t_request req;
        req = random_request(mtee_pkg::MODE_META);
        req.meta_type   = mtype;
        req.meta_length = length;
        send_request(req);
    endtask

    task automatic send_payload(input logic [7:0] value);
        t_request req;
        req = random_request(mtee_pkg::MODE_PAYLOAD);
        req.payload_byte = value;
        send_request(req);
    endtask

    task automatic drain_track_bytes();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int n;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            n = no_idle ? 0 : $urandom_range(0, 11);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_byte(o_out_byte, o_last_of_item);
        end
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        int seq;
        int len;
        int sent;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_channel(8'h00, 2'd0, 7'h00, 7'h00);
        send_channel(8'h45, 2'd1, 7'h7F, 7'h00);
        send_channel(8'h90, 2'd2, 7'h7F, 7'h00);
        send_delay(28'h7F);
        send_channel(8'h90, 2'd2, 7'h00, 7'h7F);
        send_delay(28'h80);
        send_channel(8'h90, 2'd3, 7'h12, 7'h34);
        send_delay(28'h3FFF);
        send_meta(7'h7F, 8'hFF);
        send_delay(28'h4000);
        send_meta(7'h00, 8'h00);
        send_payload(8'h00);
        send_payload(8'hFF);
        send_delay(28'h1FFFFF);
        send_channel(8'h80, 2'd0, 7'h55, 7'h2A);
        send_delay(28'h200000);
        send_channel(8'h80, 2'd2, 7'h2A, 7'h55);
        send_delay(28'hFFFFFFF);
        send_delay(28'h1);
        send_delay(28'hFFFFFFF);
        send_channel(8'hFF, 2'd2, 7'h7F, 7'h7F);
        send_meta(7'h2F, 8'h00);
        send_channel(8'hFF, 2'd1, 7'h40, 7'h00);
        send_channel(8'h90, 2'd0, 7'h00, 7'h00);
        directed_count = sb.requests_noted;

        drain_track_bytes();

        seq = 0;
        while (sb.requests_noted - directed_count < 300) begin
            if ((seq % 12) == 0) no_idle = ($urandom_range(0, 3) == 0);
            seq++;
            case ($urandom_range(0, 9))
                0, 1: begin
                    send_delay(random_delay());
                    send_channel(random_status(), 2'($urandom), 7'($urandom), 7'($urandom));
                end
                2, 3, 4: begin
                    send_channel(random_status(), 2'($urandom), 7'($urandom), 7'($urandom));
                end
                5: begin
                    send_delay(random_delay());
                end
                6, 7: begin
                    len = $urandom_range(0, 5);
                    if ($urandom_range(0, 1) == 0) send_delay(random_delay());
                    send_meta(7'($urandom), 8'(len));
                    for (sent = 0; sent < len; sent++) send_payload(8'($urandom));
                end
                8: begin
                    send_meta(7'($urandom), 8'($urandom));
                    len = $urandom_range(0, 3);
                    for (sent = 0; sent < len; sent++) send_payload(8'($urandom));
                end
                default: begin
                    send_request(random_request(mtee_pkg::t_mode'($urandom_range(0, 3))));
                end
            endcase
        end

        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected track bytes never arrived", $time, sb.pending());
            sb.mismatches++;
        end

        $display("Drove %0d requests (%0d directed) and checked %0d track bytes.",
                 sb.requests_noted, directed_count, sb.bytes_checked);
        $display("Covered delta time groups, saturation, running status and meta headers.");
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
